@@ sv/pdh_pkg.sv @@
// Package for the periodic density histogram: beat types, opcodes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package pdh_pkg;

  localparam int FRAC_BITS = 40;

  localparam logic [1:0] OP_ACCUM      = 2'd0;
  localparam logic [1:0] OP_READ_BIN   = 2'd1;
  localparam logic [1:0] OP_READ_TOTAL = 2'd2;

  localparam logic CFG_GRID_DIVS   = 1'b0;
  localparam logic CFG_INV_BOX_LEN = 1'b1;

  localparam logic [6:0]  GRID_DIVS_RESET   = 7'd64;
  localparam logic [31:0] INV_BOX_LEN_RESET = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        sample_weight;
    logic               walker_start;
    logic [17:0]        bin_select;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] total_weight;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       clr_idx;
    logic [1:0] axis;
    logic       mul_frac;
    logic       mul_bin;
    logic       acc_idx;
    logic       total_add;
    logic       mem_rd;
    logic       wr_acc;
    logic       wr_zero;
    logic       clear_wr;
    logic       load_out_bin;
    logic       load_out_total;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       weight_zero;
    logic       clear_last;
  } sts_t;

endpackage

@@ sv/pdh_datapath.sv @@
// Datapath: config registers, item register, shared axis multiplier, index
// accumulator, bin memory with read-modify-write, total and output register.
// Depends on pdh_pkg.
module pdh_datapath import pdh_pkg::*; #(
  parameter int GRID_MAX   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_data
);

  localparam int DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int GW    = $clog2(GRID_MAX + 1);
  localparam int AW    = $clog2(GRID_MAX);

  logic [6:0]           grid_divs;
  logic [31:0]          inv_box_len;
  in_item_t             item;
  logic [FRAC_BITS-1:0] frac;
  logic [AW-1:0]        bin;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     clr_cnt;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;

  logic [GW-1:0]              g;
  logic signed [31:0]         pos_sel;
  logic signed [64:0]         prod;
  logic [FRAC_BITS+GW-1:0]    scaled;
  logic [IDX_W+GW-1:0]        idx_mac;
  logic [IDX_W+17:0]          sel_ext;
  logic [IDX_W-1:0]           sel_idx;
  logic                       sel_ok;
  logic [IDX_W-1:0]           mem_addr;
  logic                       mem_we;
  logic [COUNT_BITS-1:0]      mem_wd;
  logic [COUNT_BITS:0]        bin_sum;
  logic [COUNT_BITS:0]        total_sum;
  logic [COUNT_BITS+31:0]     rd_ext;
  logic [COUNT_BITS+31:0]     total_ext;
  logic [31:0]                rd_clamp;
  logic [31:0]                total_clamp;

  always_comb begin
    if (grid_divs == 7'd0) begin
      g = GW'(1);
    end else if ({1'b0, grid_divs} > 8'(GRID_MAX)) begin
      g = GW'(GRID_MAX);
    end else begin
      g = GW'(grid_divs);
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0:    pos_sel = item.pos_x;
      2'd1:    pos_sel = item.pos_y;
      default: pos_sel = item.pos_z;
    endcase
  end

  assign prod    = 65'(pos_sel) * 65'($signed({1'b0, inv_box_len}));
  assign scaled  = (FRAC_BITS+GW)'(frac) * (FRAC_BITS+GW)'(g);
  assign idx_mac = (IDX_W+GW)'(idx) * (IDX_W+GW)'(g) + (IDX_W+GW)'(bin);

  assign sel_ext = {{IDX_W{1'b0}}, item.bin_select};
  assign sel_idx = sel_ext[IDX_W-1:0];
  assign sel_ok  = {14'd0, item.bin_select} < 32'(DEPTH);

  assign bin_sum   = {1'b0, rd_data} + (COUNT_BITS+1)'(item.sample_weight);
  assign total_sum = {1'b0, total} + (COUNT_BITS+1)'(item.sample_weight);

  assign rd_ext      = {32'd0, rd_data};
  assign total_ext   = {32'd0, total};
  assign rd_clamp    = (|rd_ext[COUNT_BITS+31:32]) ? 32'hFFFF_FFFF : rd_ext[31:0];
  assign total_clamp = (|total_ext[COUNT_BITS+31:32]) ? 32'hFFFF_FFFF : total_ext[31:0];

  always_comb begin
    if (cmd.clear_wr) begin
      mem_addr = clr_cnt;
    end else if (item.opcode == OP_READ_BIN) begin
      mem_addr = sel_idx;
    end else begin
      mem_addr = idx;
    end
    mem_we = cmd.clear_wr | cmd.wr_acc | (cmd.wr_zero & sel_ok);
    if (cmd.wr_acc) begin
      mem_wd = bin_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : bin_sum[COUNT_BITS-1:0];
    end else begin
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_divs   <= GRID_DIVS_RESET;
      inv_box_len <= INV_BOX_LEN_RESET;
      total       <= '0;
      clr_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_DIVS:   grid_divs <= cfg_data[6:0];
          CFG_INV_BOX_LEN: inv_box_len <= cfg_data;
          default:         ;
        endcase
      end
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
      if (cmd.total_add && item.walker_start) begin
        total <= total_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : total_sum[COUNT_BITS-1:0];
      end else if (cmd.load_out_total) begin
        total <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.mul_frac) begin
      frac <= prod[FRAC_BITS-1:0];
    end
    if (cmd.mul_bin) begin
      bin <= scaled[FRAC_BITS +: AW];
    end
    if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.acc_idx) begin
      idx <= idx_mac[IDX_W-1:0];
    end
    if (cmd.load_out_bin) begin
      out_data.bin_count    <= sel_ok ? rd_clamp : 32'd0;
      out_data.total_weight <= 32'd0;
    end else if (cmd.load_out_total) begin
      out_data.bin_count    <= 32'd0;
      out_data.total_weight <= total_clamp;
    end
  end

  assign sts.opcode      = item.opcode;
  assign sts.weight_zero = (item.sample_weight == 16'd0);
  assign sts.clear_last  = (clr_cnt == IDX_W'(DEPTH - 1));

endmodule

@@ sv/pdh_ctrl.sv @@
// Controller: clearing pass, item sequencing over three axes, memory
// read-modify-write and output handshake. Depends on pdh_pkg.
module pdh_ctrl import pdh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_FRAC, ST_BIN, ST_ACC,
    ST_RD, ST_UPD, ST_OUT_BIN, ST_OUT_TOTAL
  } state_t;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load_item = in_valid;
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.opcode)
          OP_ACCUM: begin
            if (sts.weight_zero) begin
              state_next = ST_IDLE;
            end else begin
              cmd.total_add = 1'b1;
              cmd.clr_idx   = 1'b1;
              axis_next     = 2'd0;
              state_next    = ST_FRAC;
            end
          end
          OP_READ_BIN:   state_next = ST_RD;
          OP_READ_TOTAL: state_next = ST_OUT_TOTAL;
          default:       state_next = ST_IDLE;
        endcase
      end
      ST_FRAC: begin
        cmd.mul_frac = 1'b1;
        state_next   = ST_BIN;
      end
      ST_BIN: begin
        cmd.mul_bin = 1'b1;
        state_next  = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_idx = 1'b1;
        if (axis == 2'd2) begin
          state_next = ST_RD;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_FRAC;
        end
      end
      ST_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = (sts.opcode == OP_READ_BIN) ? ST_OUT_BIN : ST_UPD;
      end
      ST_UPD: begin
        cmd.wr_acc = 1'b1;
        state_next = ST_IDLE;
      end
      ST_OUT_BIN: begin
        if (out_free) begin
          cmd.load_out_bin = 1'b1;
          cmd.wr_zero      = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_OUT_TOTAL: begin
        if (out_free) begin
          cmd.load_out_total = 1'b1;
          state_next         = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      axis      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= (out_valid && !out_ready) || cmd.load_out_bin || cmd.load_out_total;
    end
  end

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.wr_acc, cmd.wr_zero}))
    else $error("more than one memory write source");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out_bin || cmd.load_out_total) |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accept");

  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && !sts.clear_last) |=> state == ST_CLEAR)
    else $error("clearing pass left early");

endmodule

@@ sv/periodic_density_histogram_top.sv @@
// Channel   Signals                        Beat
// cfg       cfg_we cfg_index cfg_data       register write, no wait
// in        in_valid in_ready in_data       in_item_t
// out       out_valid out_ready out_data    out_item_t
// Accumulate: per axis the fraction, then the bin, then the index step, the three axes sharing
// one 32x33 multiplier for the fraction; then a memory read and write-back.
// Read bin: decode, memory read, output load; read total: decode, output load; ignored items: decode only.
// After reset a clearing pass zeroes all GRID_MAX^3 words of the bin memory; in_ready is low.
// A result waiting in the output register blocks only the next read that produces one.
module periodic_density_histogram_top import pdh_pkg::*; #(
  parameter int GRID_MAX   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  cmd_t cmd;
  sts_t sts;

  pdh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdh_datapath #(
    .GRID_MAX   (GRID_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

@@ verif/density_histogram_checker.sv @@
`timescale 1ns / 1ps
// Checker for the periodic density histogram: watches the cfg, in and out channels,
// predicts the read results from its own copy of the bins and total, compares them.
// Depends on pdh_pkg.
module density_histogram_checker import pdh_pkg::*; #(
  parameter int GRID_MAX   = 64,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          errors,
  output int          pending,
  output int          results
);

  localparam longint unsigned CELLS     = longint'(GRID_MAX) ** 3;
  localparam logic [63:0]     COUNT_CAP = (64'd1 << COUNT_BITS) - 64'd1;

  logic [63:0] bin_counts [int unsigned];
  logic [63:0] walker_sum;
  logic [6:0]  grid_reg;
  logic [31:0] inv_len;
  out_item_t   readouts [$];
  out_item_t   want;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > COUNT_CAP) ? COUNT_CAP : s;
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic int unsigned grid_used();
    int unsigned g;
    g = 32'(grid_reg);
    if (g == 0) g = 1;
    if (g > GRID_MAX) g = GRID_MAX;
    return g;
  endfunction

  // wrapped fraction of pos * 1/L (Q24.40 product), scaled to a bin
  function automatic int unsigned axis_cell(logic [31:0] pos, int unsigned g);
    logic [63:0] prod;
    logic [63:0] scaled;
    prod   = {{32{pos[31]}}, pos} * {32'd0, inv_len};
    scaled = {24'd0, prod[FRAC_BITS-1:0]} * 64'(g);
    return int'(scaled >> FRAC_BITS);
  endfunction

  task automatic predict(in_item_t it);
    int unsigned g;
    int unsigned slot;
    logic [63:0] v;
    out_item_t   r;
    case (it.opcode)
      OP_ACCUM: begin
        if (it.sample_weight != 16'd0) begin
          if (it.walker_start) walker_sum = sat_sum(walker_sum, 64'(it.sample_weight));
          g    = grid_used();
          slot = (axis_cell(it.pos_x, g) * g + axis_cell(it.pos_y, g)) * g
                 + axis_cell(it.pos_z, g);
          v    = bin_counts.exists(slot) ? bin_counts[slot] : 64'd0;
          bin_counts[slot] = sat_sum(v, 64'(it.sample_weight));
        end
      end
      OP_READ_BIN: begin
        slot = int'(it.bin_select);
        v    = 64'd0;
        if (slot < CELLS && bin_counts.exists(slot)) begin
          v = bin_counts[slot];
          bin_counts.delete(slot);
        end
        r.bin_count    = clamp32(v);
        r.total_weight = 32'd0;
        readouts.insert(readouts.size(), r);
      end
      OP_READ_TOTAL: begin
        r.bin_count    = 32'd0;
        r.total_weight = clamp32(walker_sum);
        walker_sum     = 64'd0;
        readouts.insert(readouts.size(), r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bin_counts.delete();
      readouts.delete();
      walker_sum = 64'd0;
      grid_reg   = GRID_DIVS_RESET;
      inv_len    = INV_BOX_LEN_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_DIVS) grid_reg = cfg_data[6:0];
        else inv_len = cfg_data;
      end
      if (out_valid && out_ready) begin
        results++;
        if (readouts.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat: bin_count %h total_weight %h",
                     $realtime, out_data.bin_count, out_data.total_weight);
        end else begin
          want = readouts.pop_front();
          if (want.bin_count !== out_data.bin_count ||
              want.total_weight !== out_data.total_weight) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: bin_count exp %h got %h, total_weight exp %h got %h",
                       $realtime, want.bin_count, out_data.bin_count,
                       want.total_weight, out_data.total_weight);
          end
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
    pending = readouts.size();
  end

endmodule

@@ verif/tb_periodic_density_histogram_top.sv @@
`timescale 1ns / 1ps
// Testbench top for periodic_density_histogram_top: clock, reset, register writes,
// directed and random beats with idling and back-pressure, watchdog and verdict.
// Depends on pdh_pkg, periodic_density_histogram_top and density_histogram_checker.
module tb_periodic_density_histogram_top;
  import pdh_pkg::*;

  localparam int          GRID_MAX     = 64;
  localparam int          COUNT_BITS   = 32;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_ITEMS  = 175;
  localparam int          IDLE_LIMIT   = 800000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_CYCLES = 300;
  localparam int          STALL_PHASE  = 2;
  localparam int          PAUSE_PHASE  = 5;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [17:0] SEL_MAX      = 18'h3FFFF;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_GRID_DIVS;
  logic [31:0] cfg_data  = 32'd0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int          errors;
  int          pending;
  int          results;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          stall_req    = 1'b0;
  int          n_items      = 0;
  int          n_accum      = 0;
  int          n_reads      = 0;
  int          idle_cycles;
  int unsigned cells        = 262144;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  periodic_density_histogram_top #(
    .GRID_MAX  (GRID_MAX),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  density_histogram_checker #(
    .GRID_MAX  (GRID_MAX),
    .COUNT_BITS(COUNT_BITS)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .results  (results)
  );

  // receiver; a requested hold-off is counted here
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        repeat (STALL_CYCLES) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [15:0] w, logic start,
                                         logic [17:0] sel);
    in_item_t it;
    it.opcode        = op;
    it.pos_x         = x;
    it.pos_y         = y;
    it.pos_z         = z;
    it.sample_weight = w;
    it.walker_start  = start;
    it.bin_select    = sel;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it = make_item(OP_ACCUM, $urandom(), $urandom(), $urandom(),
                   16'($urandom_range(65535)), 1'($urandom_range(1)),
                   18'($urandom_range(262143)));
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(9) == 0) it.sample_weight = 16'd0;
      else if ($urandom_range(19) == 0) it.sample_weight = 16'hFFFF;
    end else if (pick < 85) begin
      it.opcode = OP_READ_BIN;
      if ($urandom_range(9) < 7) it.bin_select = 18'($urandom_range(cells - 1));
    end else if (pick < 95) begin
      it.opcode = OP_READ_TOTAL;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // entered and left at a falling edge; valid stays up after the beat
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    n_items++;
    if (it.opcode == OP_ACCUM) n_accum++;
    if (it.opcode == OP_READ_BIN || it.opcode == OP_READ_TOTAL) n_reads++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_cfg(logic [6:0] grid, logic [31:0] inv);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRID_DIVS;
    cfg_data  <= {25'd0, grid};
    @(negedge clk);
    cfg_index <= CFG_INV_BOX_LEN;
    cfg_data  <= inv;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    push_item(make_item(OP_ACCUM, 32'd0, 32'd0, 32'd0, 16'd1, 1'b1, 18'd0));
    push_item(make_item(OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF,
                        1'b1, SEL_MAX));
    push_item(make_item(OP_ACCUM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                        1'b0, 18'd0));
    push_item(make_item(OP_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd5,
                        1'b1, 18'h2AAAA));
    push_item(make_item(OP_ACCUM, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_8000, 16'h1234,
                        1'b0, 18'h15555));
    // zero weight: nothing changes even with walker_start
    push_item(make_item(OP_ACCUM, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, SEL_MAX));
    push_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                        1'b1, SEL_MAX));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 18'd0));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 18'd0));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, SEL_MAX));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 18'd133152));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, 18'h2AAAA));
    push_item(make_item(OP_READ_BIN, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 18'h15555));
    push_item(make_item(OP_READ_TOTAL, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 18'd0));
    push_item(make_item(OP_READ_TOTAL, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'hFFFF, 1'b1, SEL_MAX));
  endtask

  initial begin
    logic [6:0]  phase_grid [NUM_PHASES];
    logic [31:0] phase_inv  [NUM_PHASES];
    in_item_t    it;
    int unsigned g;

    phase_grid = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd4, 7'd3, 7'd100, 7'd7};
    phase_inv  = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0000, $urandom(),
                   32'h0100_0000, $urandom(), 32'h0080_0000, $urandom()};

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        src_idle_pct = 16;
        snk_idle_pct = 85;
      end else if (p < 6) begin
        src_idle_pct = 85;
        snk_idle_pct = 16;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_cfg(phase_grid[p], phase_inv[p]);
      g = 32'(phase_grid[p]);
      if (g == 0) g = 1;
      if (g > GRID_MAX) g = GRID_MAX;
      cells = g * g * g;

      if (p == 0) run_directed();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == STALL_PHASE && i == PHASE_ITEMS / 2) begin
          // long receiver hold-off with a burst of reads behind it
          stall_req = 1'b1;
          for (int k = 0; k < 24; k++) begin
            it = random_item();
            it.opcode = (k % 4 == 3) ? OP_READ_TOTAL : OP_READ_BIN;
            push_item(it);
          end
        end
        if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_drained();
        push_item(random_item());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    $display("Run covered %0d input beats (%0d accumulates, %0d reads) over %0d register settings,",
             n_items, n_accum, n_reads, NUM_PHASES);
    $display("with %0d read results checked under mixed idling and back-pressure.", results);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pdh_pkg.sv
sv/pdh_datapath.sv
sv/pdh_ctrl.sv
sv/periodic_density_histogram_top.sv
verif/density_histogram_checker.sv
verif/tb_periodic_density_histogram_top.sv
